// File: design/clock_page_replacer_core_macros.svh
// Assertion helpers shared by the RTL.
`ifndef CLOCK_PAGE_REPLACER_CORE_MACROS_SVH
`define CLOCK_PAGE_REPLACER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/crp_pkg.sv
package crp_pkg;

  typedef logic [1:0] status_t;
  typedef logic [1:0] action_t;

  localparam status_t ST_PINNED    = 2'd0;
  localparam status_t ST_UNTOUCHED = 2'd1;
  localparam status_t ST_ACCESSED  = 2'd2;
  localparam status_t ST_RSVD      = 2'd3;

  localparam action_t ACT_VICTIM = 2'd0;
  localparam action_t ACT_PIN    = 2'd1;
  localparam action_t ACT_UNPIN  = 2'd2;
  localparam action_t ACT_COUNT  = 2'd3;

  localparam int unsigned FRAME_W = 6;
  localparam int unsigned COUNT_W = 7;

endpackage

// File: design/crp_in_if.sv
interface crp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] frame;

  modport source (output valid, output action, output frame, input ready);
  modport sink   (input valid, input action, input frame, output ready);
endinterface

// File: design/crp_out_if.sv
interface crp_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [5:0] victim_frame;
  logic [6:0] evictable_count;

  modport source (output valid, output found, output victim_frame,
                  output evictable_count, input ready);
  modport sink   (input valid, input found, input victim_frame,
                  input evictable_count, output ready);
endinterface

// File: design/clock_page_replacer_core.sv
// Clock page replacer.
// in_i (sink): one beat carries action and frame. in_i.ready is high only in
//   the idle state; one item is worked on at a time.
// out_o (source): exactly one result beat per input beat, held in an output
//   register until taken; the next input beat can be taken while it waits.
// Steps from accept to result valid:
//   count query   : straight from idle to S_DONE
//   pin / unpin   : S_MOD subtracts NUM_FRAMES from frame until in range
//                   (one subtractor); then S_RD, S_UPD and S_DONE
//   victim        : S_SWEEP, S_SWAIT, S_PICK; the sweep reads one status entry
//                   per cycle through the single read port of the status RAM
// Reset: a clearing pass writes every status entry to pinned; in_i.ready
//   stays low until it ends. Hand and count reset to zero.
// A stalled out_o holds the result; a finished item waits in its last state
//   until the output register frees up.
`include "clock_page_replacer_core_macros.svh"

module clock_page_replacer_core #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crp_in_if.sink    in_i,
  crp_out_if.source out_o
);
  import crp_pkg::*;

  localparam int unsigned FW = $clog2(NUM_FRAMES);
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned IW = ((FW > FRAME_W) ? FW : FRAME_W) + 1;
  localparam logic [FW-1:0] LAST_IDX = FW'(NUM_FRAMES - 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [IW-1:0] N_IW     = IW'(NUM_FRAMES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_SWEEP = 4'd5;
  localparam logic [3:0] S_SWAIT = 4'd6;
  localparam logic [3:0] S_PICK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  function automatic logic [FW-1:0] next_idx(input logic [FW-1:0] a);
    next_idx = (a == LAST_IDX) ? '0 : a + FW'(1);
  endfunction

  logic [3:0]    state_q, state_d;
  logic [FW-1:0] hand_q, hand_d;
  logic [CW-1:0] ev_cnt_q, ev_cnt_d;
  logic [FW-1:0] clr_addr_q, clr_addr_d;
  logic [FW-1:0] sw_addr_q, sw_addr_d;
  logic [CW-1:0] sw_cnt_q, sw_cnt_d;
  action_t       act_q, act_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          res_found_q, res_found_d;

  status_t       mem_q [NUM_FRAMES];
  status_t       rd_q;
  logic          rd_en;
  logic [FW-1:0] raddr;
  logic          pvalid_q;
  logic [FW-1:0] paddr_q;
  logic          mem_we;
  logic [FW-1:0] mem_waddr;
  status_t       mem_wdata;

  logic          in_acc;
  logic          sweeping;
  logic          pick_start;
  logic          pick_found;
  logic [FW-1:0] pick_idx;
  logic          old_evict;

  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q;
  logic [FRAME_W-1:0]   out_victim_q;
  logic [COUNT_W-1:0]   out_count_q;
  logic                 out_load;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign sweeping   = (state_q == S_SWEEP) || (state_q == S_SWAIT);
  assign pick_start = in_acc && (in_i.action == ACT_VICTIM);
  assign old_evict  = (rd_q == ST_UNTOUCHED) || (rd_q == ST_ACCESSED);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  crp_pick #(.FW(FW)) u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pick_start),
    .valid_i  (pvalid_q && sweeping),
    .status_i (rd_q),
    .idx_i    (paddr_q),
    .found_o  (pick_found),
    .idx_o    (pick_idx)
  );

  always_comb begin
    state_d     = state_q;
    hand_d      = hand_q;
    ev_cnt_d    = ev_cnt_q;
    clr_addr_d  = clr_addr_q;
    sw_addr_d   = sw_addr_q;
    sw_cnt_d    = sw_cnt_q;
    act_d       = act_q;
    idx_d       = idx_q;
    res_found_d = res_found_q;
    rd_en       = 1'b0;
    raddr       = sw_addr_q;
    mem_we      = 1'b0;
    mem_waddr   = paddr_q;
    mem_wdata   = ST_PINNED;
    unique case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = next_idx(clr_addr_q);
        if (clr_addr_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          act_d       = in_i.action;
          idx_d       = IW'(in_i.frame);
          res_found_d = 1'b0;
          sw_addr_d   = next_idx(hand_q);
          sw_cnt_d    = '0;
          unique case (in_i.action)
            ACT_VICTIM:          state_d = S_SWEEP;
            ACT_PIN, ACT_UNPIN:  state_d = S_MOD;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_MOD: begin
        if (idx_q >= N_IW) idx_d = idx_q - N_IW;
        else               state_d = S_RD;
      end
      S_RD: begin
        rd_en   = 1'b1;
        raddr   = idx_q[FW-1:0];
        state_d = S_UPD;
      end
      S_UPD: begin
        mem_we = 1'b1;
        if (act_q == ACT_PIN) begin
          mem_wdata = ST_PINNED;
          if (old_evict) ev_cnt_d = ev_cnt_q - CNT_ONE;
        end else begin
          mem_wdata = ST_ACCESSED;
          if (!old_evict) ev_cnt_d = ev_cnt_q + CNT_ONE;
        end
        state_d = S_DONE;
      end
      S_SWEEP: begin
        rd_en     = 1'b1;
        sw_addr_d = next_idx(sw_addr_q);
        sw_cnt_d  = sw_cnt_q + CNT_ONE;
        if (pvalid_q && rd_q == ST_ACCESSED) begin
          mem_we    = 1'b1;
          mem_wdata = ST_UNTOUCHED;
        end
        if (sw_cnt_q == CW'(NUM_FRAMES - 1)) state_d = S_SWAIT;
      end
      S_SWAIT: begin
        if (pvalid_q && rd_q == ST_ACCESSED) begin
          mem_we    = 1'b1;
          mem_wdata = ST_UNTOUCHED;
        end
        state_d = S_PICK;
      end
      S_PICK: begin
        if (pick_found) begin
          mem_we      = 1'b1;
          mem_waddr   = pick_idx;
          mem_wdata   = ST_PINNED;
          hand_d      = pick_idx;
          ev_cnt_d    = ev_cnt_q - CNT_ONE;
          res_found_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)                        out_valid_d = 1'b1;
    else if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      hand_q      <= '0;
      ev_cnt_q    <= '0;
      clr_addr_q  <= '0;
      sw_cnt_q    <= '0;
      res_found_q <= 1'b0;
      pvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hand_q      <= hand_d;
      ev_cnt_q    <= ev_cnt_d;
      clr_addr_q  <= clr_addr_d;
      sw_cnt_q    <= sw_cnt_d;
      res_found_q <= res_found_d;
      pvalid_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    idx_q     <= idx_d;
    sw_addr_q <= sw_addr_d;
    paddr_q   <= raddr;
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_victim_q <= res_found_q ? FRAME_W'(hand_q) : '0;
      out_count_q  <= COUNT_W'(ev_cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rd_en)  rd_q <= mem_q[raddr];
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.found           = out_found_q;
  assign out_o.victim_frame    = out_victim_q;
  assign out_o.evictable_count = out_count_q;

  `CRP_ASSERT_IMP(a_cnt_range, 1'b1, ev_cnt_q <= CW'(NUM_FRAMES), "evictable count overflow")
  `CRP_ASSERT_IMP(a_hand_range, 1'b1, hand_q <= LAST_IDX, "clock hand out of range")
  `CRP_ASSERT_IMP(a_no_rsvd, mem_we, mem_wdata != ST_RSVD, "reserved status written")
  `CRP_ASSERT_NXT(a_hand_move, state_q == S_PICK && pick_found,
                  hand_q == $past(pick_idx), "hand not moved to victim")

endmodule

// File: design/crp_pick.sv
module crp_pick #(
  parameter int unsigned FW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             valid_i,
  input  crp_pkg::status_t status_i,
  input  logic [FW-1:0]    idx_i,
  output logic             found_o,
  output logic [FW-1:0]    idx_o
);
  import crp_pkg::*;

  logic          have_old_q, have_old_d;
  logic          have_new_q, have_new_d;
  logic [FW-1:0] old_q, old_d;
  logic [FW-1:0] new_q, new_d;

  always_comb begin
    have_old_d = have_old_q;
    have_new_d = have_new_q;
    old_d      = old_q;
    new_d      = new_q;
    if (start_i) begin
      have_old_d = 1'b0;
      have_new_d = 1'b0;
    end else if (valid_i) begin
      if (status_i == ST_UNTOUCHED && !have_old_q) begin
        have_old_d = 1'b1;
        old_d      = idx_i;
      end
      if (status_i == ST_ACCESSED && !have_new_q) begin
        have_new_d = 1'b1;
        new_d      = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_old_q <= 1'b0;
      have_new_q <= 1'b0;
    end else begin
      have_old_q <= have_old_d;
      have_new_q <= have_new_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_q <= old_d;
    new_q <= new_d;
  end

  assign found_o = have_old_q | have_new_q;
  assign idx_o   = have_old_q ? old_q : new_q;

endmodule
